// ===== rtl/core/gqpm_pkg.sv =====
// Shared types, constants and constant tables of the Gray QAM/PSK mapper and demapper.
package gqpm_pkg;

	localparam int MAX_BITS   = 6;
	localparam int COORD_FRAC = 14;
	localparam int NPTS       = 1 << MAX_BITS;
	localparam int ADDR_W     = MAX_BITS;
	localparam int IDX_W      = 6;
	localparam int KW         = 3;
	localparam int CRD_W      = 16;
	localparam int PNT_W      = 2 * CRD_W;
	localparam int CFG_IDX_W  = 1;
	localparam int DIST_W     = 2 * CRD_W + 1;

	localparam int FRAC_SH    = 31 - MAX_BITS;
	localparam int FW         = MAX_BITS - 1;
	localparam int OCT_STEPS  = 1 << (MAX_BITS - 2);

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam longint unsigned RND_Q30 = 64'd1 << (29 - COORD_FRAC);

	localparam logic            CMD_MOD   = 1'b0;
	localparam logic            CMD_DEMOD = 1'b1;
	localparam logic            KIND_QAM  = 1'b0;
	localparam logic            KIND_PSK  = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_KIND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITS = 1'b1;
	localparam logic [KW-1:0]   RST_BITS  = 3'd4;

	localparam int QSC = 1 << (COORD_FRAC + 1);

	// QAM level magnitudes, indexed by half bit count minus one and by |2j-(L-1)|/2.
	localparam logic [CRD_W-1:0] QAM_LVL [0:2][0:3] = '{
		'{CRD_W'((QSC + 1) / 2), CRD_W'(0), CRD_W'(0), CRD_W'(0)},
		'{CRD_W'((QSC + 3) / 6), CRD_W'((3 * QSC + 3) / 6), CRD_W'(0), CRD_W'(0)},
		'{CRD_W'((QSC + 7) / 14), CRD_W'((3 * QSC + 7) / 14),
			CRD_W'((5 * QSC + 7) / 14), CRD_W'((7 * QSC + 7) / 14)}
	};

	typedef logic [OCT_STEPS:0][CRD_W-1:0] trig_tab_t;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        symbol_index;
		logic signed [CRD_W-1:0] in_i;
		logic signed [CRD_W-1:0] in_q;
	} sym_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] out_i;
		logic signed [CRD_W-1:0] out_q;
		logic [IDX_W-1:0]        out_index;
	} res_t;

	typedef struct packed {
		logic          psk;
		logic [KW-1:0] bits;
	} mode_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PNT_W-1:0]  data;
	} pnt_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_DRAIN,
		ST_PUT
	} srch_state_t;

	// Rounded sine or cosine magnitudes over the first octant, one entry per angle step.
	function automatic trig_tab_t trig_table(input logic want_sin);
		trig_tab_t         tab;
		longint unsigned   r;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   t;
		longint unsigned   s;
		longint unsigned   c;
		for (int j = 0; j <= OCT_STEPS; j++) begin
			r = 64'(j) << FRAC_SH;
			x = (r * PI_Q30) >> 31;
			x2 = (x * x) >> 30;
			t = x;
			s = x;
			t = ((t * x2) >> 30) / 6;
			s = s - t;
			t = ((t * x2) >> 30) / 20;
			s = s + t;
			t = ((t * x2) >> 30) / 42;
			s = s - t;
			t = ((t * x2) >> 30) / 72;
			s = s + t;
			t = ONE_Q30;
			c = ONE_Q30;
			t = ((t * x2) >> 30) / 2;
			c = c - t;
			t = ((t * x2) >> 30) / 12;
			c = c + t;
			t = ((t * x2) >> 30) / 30;
			c = c - t;
			t = ((t * x2) >> 30) / 56;
			c = c + t;
			t = ((t * x2) >> 30) / 90;
			c = c - t;
			tab[j] = CRD_W'(((want_sin ? s : c) + RND_Q30) >> (30 - COORD_FRAC));
		end
		return tab;
	endfunction

endpackage

// ===== rtl/core/gqpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gqpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/gqpm_fill.sv =====
// Fill sequencer that computes every constellation point and writes it to the point RAM.
module gqpm_fill import gqpm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    restart,
	input  mode_t   mode,
	output pnt_wr_t wr,
	output logic    busy
);

	localparam trig_tab_t COS_TAB = trig_table(1'b0);
	localparam trig_tab_t SIN_TAB = trig_table(1'b1);

	logic [ADDR_W-1:0] cnt_q;
	logic              busy_q;

	logic [ADDR_W-1:0]        idx;
	logic [ADDR_W-1:0]        g;
	logic [31:0]              ph;
	logic [1:0]               quad;
	logic [FW-1:0]            f;
	logic [FW-1:0]            j;
	logic                     swap;
	logic [CRD_W-1:0]         cm;
	logic [CRD_W-1:0]         sm;
	logic [CRD_W-1:0]         psk_i;
	logic [CRD_W-1:0]         psk_q;
	logic [1:0]               h;
	logic [1:0]               hsel;
	logic [ADDR_W-1:0]        lm;
	logic [ADDR_W-1:0]        row;
	logic [ADDR_W-1:0]        col;
	logic signed [ADDR_W+1:0] nr;
	logic signed [ADDR_W+1:0] ni;
	logic [ADDR_W+1:0]        ar;
	logic [ADDR_W+1:0]        ai;
	logic [CRD_W-1:0]         vr;
	logic [CRD_W-1:0]         vi;
	logic [CRD_W-1:0]         qam_i;
	logic [CRD_W-1:0]         qam_q;

	function automatic logic [ADDR_W-1:0] gray_inv(input logic [ADDR_W-1:0] v);
		logic [ADDR_W-1:0] r;
		r = v;
		for (int s = 1; s < ADDR_W; s = s * 2) begin
			r = r ^ (r >> s);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (restart) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ADDR_W'(NPTS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		idx  = cnt_q;
		g    = idx ^ (idx >> 1);
		ph   = 32'({g, 1'b1}) << (5'd31 - 5'(mode.bits));
		quad = ph[31:30];
		f    = ph[29 -: FW];
		swap = (f > FW'(OCT_STEPS));
		j    = swap ? (FW'(2 * OCT_STEPS) - f) : f;
		cm   = swap ? SIN_TAB[j] : COS_TAB[j];
		sm   = swap ? COS_TAB[j] : SIN_TAB[j];
		case (quad)
			2'd0: begin
				psk_i = cm;
				psk_q = sm;
			end
			2'd1: begin
				psk_i = -sm;
				psk_q = cm;
			end
			2'd2: begin
				psk_i = -cm;
				psk_q = -sm;
			end
			default: begin
				psk_i = sm;
				psk_q = -cm;
			end
		endcase
	end

	always_comb begin
		h     = mode.bits[KW-1:1];
		hsel  = (h == 2'd0) ? 2'd0 : h - 2'd1;
		lm    = ~(ADDR_W'('1) << h);
		row   = gray_inv(idx >> h) & lm;
		col   = gray_inv(idx & lm) & lm;
		nr    = $signed({1'b0, col, 1'b0}) - $signed({2'b00, lm});
		ni    = $signed({2'b00, lm}) - $signed({1'b0, row, 1'b0});
		ar    = nr[ADDR_W+1] ? -nr : nr;
		ai    = ni[ADDR_W+1] ? -ni : ni;
		vr    = QAM_LVL[hsel][ar[2:1]];
		vi    = QAM_LVL[hsel][ai[2:1]];
		qam_i = nr[ADDR_W+1] ? -vr : vr;
		qam_q = ni[ADDR_W+1] ? -vi : vi;
	end

	always_comb begin
		wr.en   = busy_q;
		wr.addr = idx;
		wr.data = (mode.psk == KIND_PSK) ? {psk_i, psk_q} : {qam_i, qam_q};
	end

	assign busy = busy_q;

endmodule

// ===== rtl/core/gqpm_search.sv =====
// Transaction control, point RAM reads, nearest-point search and output register.
module gqpm_search import gqpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mode_t             mode,
	input  logic              fill_busy,
	input  logic              sym_valid,
	output logic              sym_ready,
	input  sym_t              sym,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	output logic [ADDR_W-1:0] raddr,
	input  logic [PNT_W-1:0]  rdata
);

	srch_state_t state_q;
	srch_state_t state_nxt;

	logic [ADDR_W-1:0]       mask;
	logic                    accept;
	logic                    issue;
	logic                    mod_cap;
	logic                    scan_done;
	logic                    put;

	logic signed [CRD_W-1:0] ri_q;
	logic signed [CRD_W-1:0] rq_q;
	logic [ADDR_W-1:0]       idx_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    rd_v_s1;
	logic [ADDR_W-1:0]       n_s1;
	logic                    v_s2;
	logic [ADDR_W-1:0]       n_s2;
	logic [2*CRD_W-1:0]      sq_i_s2;
	logic [2*CRD_W-1:0]      sq_q_s2;
	logic [DIST_W-1:0]       best_q;
	logic [ADDR_W-1:0]       bidx_q;
	res_t                    core_q;
	res_t                    res_q;
	logic                    res_valid_q;

	logic signed [CRD_W-1:0]   xi;
	logic signed [CRD_W-1:0]   xq;
	logic signed [CRD_W:0]     di;
	logic signed [CRD_W:0]     dq;
	logic signed [2*CRD_W+1:0] sqi;
	logic signed [2*CRD_W+1:0] sqq;
	logic [DIST_W-1:0]         d2;

	assign mask = ~(ADDR_W'('1) << mode.bits);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sym_valid && !fill_busy) begin
					state_nxt = (sym.cmd == CMD_DEMOD) ? ST_SCAN : ST_MOD;
				end
			end
			ST_MOD: state_nxt = ST_PUT;
			ST_SCAN: begin
				if (addr_q == mask) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !v_s2) begin
					state_nxt = ST_PUT;
				end
			end
			ST_PUT: begin
				if (!res_valid_q || res_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		sym_ready = 1'b0;
		issue     = 1'b0;
		mod_cap   = 1'b0;
		scan_done = 1'b0;
		put       = 1'b0;
		raddr     = ADDR_W'(sym.symbol_index) & mask;
		unique case (state_q)
			ST_IDLE:  sym_ready = !fill_busy;
			ST_MOD:   mod_cap = 1'b1;
			ST_SCAN: begin
				issue = 1'b1;
				raddr = addr_q;
			end
			ST_DRAIN: scan_done = !rd_v_s1 && !v_s2;
			ST_PUT:   put = !res_valid_q || res_ready;
			default: begin
				sym_ready = 1'b0;
			end
		endcase
	end

	assign accept = sym_valid && sym_ready;

	always_comb begin
		xi  = rdata[PNT_W-1:CRD_W];
		xq  = rdata[CRD_W-1:0];
		di  = (CRD_W + 1)'(ri_q) - (CRD_W + 1)'(xi);
		dq  = (CRD_W + 1)'(rq_q) - (CRD_W + 1)'(xq);
		sqi = di * di;
		sqq = dq * dq;
		d2  = {1'b0, sq_i_s2} + {1'b0, sq_q_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1;
			if (put) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ri_q   <= sym.in_i;
			rq_q   <= sym.in_q;
			idx_q  <= ADDR_W'(sym.symbol_index) & mask;
			addr_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
		end
		n_s1    <= addr_q;
		n_s2    <= n_s1;
		sq_i_s2 <= sqi[2*CRD_W-1:0];
		sq_q_s2 <= sqq[2*CRD_W-1:0];
		if (v_s2 && (n_s2 == '0 || d2 < best_q)) begin
			best_q <= d2;
			bidx_q <= n_s2;
		end
		if (mod_cap) begin
			core_q.out_i     <= xi;
			core_q.out_q     <= xq;
			core_q.out_index <= IDX_W'(idx_q);
		end else if (scan_done) begin
			core_q.out_i     <= '0;
			core_q.out_q     <= '0;
			core_q.out_index <= IDX_W'(bidx_q);
		end
		if (put) begin
			res_q <= core_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/gray_qam_psk_mapper_demapper.sv =====
// Top level of the Gray-coded QAM/PSK constellation mapper and demapper.
// A modulate transaction makes one point RAM read and passes through the MOD and PUT states.
// A demodulate transaction makes one point RAM read per candidate, then the distance and
// compare pipeline drains. One transaction is in work at a time.
// After reset and after every configuration write, a fill pass rebuilds the point RAM
// and no symbol transaction is accepted until it ends.
module gray_qam_psk_mapper_demapper import gqpm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	output logic                 sym_ready,
	input  sym_t                 sym,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KW-1:0]        cfg_data
);

	logic              kind_q;
	logic [KW-1:0]     bits_q;
	logic              cfg_wr;
	logic [KW-1:0]     k;
	mode_t             mode;
	pnt_wr_t           wr;
	logic              fill_busy;
	logic [ADDR_W-1:0] raddr;
	logic [PNT_W-1:0]  rdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_QAM;
			bits_q <= RST_BITS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_KIND: kind_q <= cfg_data[0];
				CFG_BITS: bits_q <= cfg_data;
				default:  bits_q <= bits_q;
			endcase
		end
	end

	// Bit count 0 is 1, over 6 is 6; QAM takes the even count below, at least 2.
	always_comb begin
		k = bits_q;
		if (k == '0) begin
			k = KW'(1);
		end
		if (k > KW'(MAX_BITS)) begin
			k = KW'(MAX_BITS);
		end
		if (kind_q == KIND_QAM) begin
			k[0] = 1'b0;
			if (k < KW'(2)) begin
				k = KW'(2);
			end
		end
		mode.psk  = kind_q;
		mode.bits = k;
	end

	gqpm_fill u_fill (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.mode    (mode),
		.wr      (wr),
		.busy    (fill_busy)
	);

	gqpm_ram #(
		.WIDTH (PNT_W),
		.DEPTH (NPTS)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	gqpm_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.fill_busy (fill_busy),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym       (sym),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.raddr     (raddr),
		.rdata     (rdata)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Gray-coded QAM/PSK constellation mapper and demapper.
module testbench import gqpm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int              TOP_BITS  = 6;
	localparam int              FRAC      = 14;
	localparam longint unsigned PI_FIX    = 64'd3373259426;
	localparam longint unsigned UNIT_FIX  = 64'd1073741824;
	localparam int              MAX_CYCLES = 1000000;
	localparam int              PHASES    = 10;
	localparam int              PER_PHASE = 80;

	typedef struct packed {
		logic                    kind;
		logic [KW-1:0]           bits;
		logic                    cmd;
		logic [IDX_W-1:0]        idx;
		logic signed [CRD_W-1:0] ii;
		logic signed [CRD_W-1:0] qq;
		logic                    typed;
		logic signed [CRD_W-1:0] ei;
		logic signed [CRD_W-1:0] eq;
		logic [IDX_W-1:0]        eidx;
	} dir_row_t;

	localparam int DIR_N = 24;
	localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
		'{KIND_QAM, 3'd4, CMD_MOD, 6'd0, 16'sd0, 16'sd0, 1'b1, -16'sd16384, 16'sd16384, 6'd0},
		'{KIND_QAM, 3'd4, CMD_MOD, 6'd63, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd4, CMD_MOD, 6'd15, -16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd4, CMD_DEMOD, 6'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd4, CMD_DEMOD, 6'd63, 16'sd32767, 16'sd32767, 1'b0,
			16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd4, CMD_DEMOD, 6'd0, -16'sd32768, -16'sd32768, 1'b0,
			16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd4, CMD_DEMOD, 6'd21, 16'sd32767, -16'sd32768, 1'b0,
			16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd0, CMD_MOD, 6'd0, 16'sd0, 16'sd0, 1'b1, -16'sd16384, 16'sd16384, 6'd0},
		'{KIND_QAM, 3'd0, CMD_MOD, 6'd63, 16'sd0, 16'sd0, 1'b1, 16'sd16384, -16'sd16384, 6'd3},
		'{KIND_QAM, 3'd1, CMD_DEMOD, 6'd42, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd5, CMD_MOD, 6'd63, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd7, CMD_MOD, 6'd63, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd6, CMD_DEMOD, 6'd0, -16'sd32768, 16'sd32767, 1'b0,
			16'sd0, 16'sd0, 6'd0},
		'{KIND_QAM, 3'd6, CMD_DEMOD, 6'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd1, CMD_MOD, 6'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd16384, 6'd0},
		'{KIND_PSK, 3'd1, CMD_MOD, 6'd63, 16'sd0, 16'sd0, 1'b1, 16'sd0, -16'sd16384, 6'd1},
		'{KIND_PSK, 3'd0, CMD_DEMOD, 6'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd3, CMD_MOD, 6'd5, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd6, CMD_MOD, 6'd63, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd6, CMD_DEMOD, 6'd0, 16'sd32767, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd7, CMD_DEMOD, 6'd0, -16'sd32768, -16'sd32768, 1'b0,
			16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd7, CMD_MOD, 6'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd2, CMD_DEMOD, 6'd0, 16'sd0, -16'sd32768, 1'b0, 16'sd0, 16'sd0, 6'd0},
		'{KIND_PSK, 3'd4, CMD_MOD, 6'd10, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 6'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sym_valid = 1'b0;
	logic                 sym_ready;
	sym_t                 sym = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KW-1:0]        cfg_data = '0;

	logic          mode_kind;
	logic [KW-1:0] mode_bits;
	res_t          pending_res [$];
	int            fails = 0;
	int            n_items = 0;
	int            n_demod = 0;
	int            n_checked = 0;
	int            n_settings = 0;
	int            cycles = 0;
	int            burst_left = 1;
	int            stall_mode = 0;
	int            stall_cnt = 0;

	gray_qam_psk_mapper_demapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym       (sym),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned order_bits(logic kind, logic [KW-1:0] bits);
		int unsigned k;
		k = 32'(bits);
		if (k < 1) k = 1;
		if (k > TOP_BITS) k = TOP_BITS;
		if (kind == KIND_PSK) return k;
		k = k & ~32'd1;
		if (k < 2) k = 2;
		return k;
	endfunction

	function automatic int unsigned gray_to_bin(int unsigned g);
		for (int s = 1; s < 16; s = s << 1) g = g ^ (g >> s);
		return g;
	endfunction

	function automatic void octant_trig(input longint unsigned r,
			output longint unsigned c, output longint unsigned s);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned acc;
		x = (r * PI_FIX) >> 31;
		x2 = (x * x) >> 30;
		t = x;
		acc = x;
		for (int n = 1; n <= 4; n++) begin
			t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - t : acc + t;
		end
		s = acc;
		t = UNIT_FIX;
		acc = UNIT_FIX;
		for (int n = 1; n <= 5; n++) begin
			t = ((t * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
			acc = (n % 2 == 1) ? acc - t : acc + t;
		end
		c = acc;
	endfunction

	function automatic int fix_round(longint unsigned v);
		return int'((v + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
	endfunction

	function automatic void const_point(input logic kind, input int unsigned k,
			input int unsigned idx, output int xi, output int xq);
		int unsigned     g;
		longint unsigned ph;
		int unsigned     quad;
		longint unsigned f;
		longint unsigned c;
		longint unsigned s;
		int              ci;
		int              si;
		int unsigned     h;
		int unsigned     lm;
		int              row;
		int              col;
		int              nr;
		int              ni;
		int              vr;
		int              vi;
		if (kind == KIND_PSK) begin
			g = idx ^ (idx >> 1);
			ph = (longint'(2 * g + 1) << (31 - k)) & 64'hFFFF_FFFF;
			quad = int'(ph >> 30);
			f = ph & (UNIT_FIX - 1);
			if (f <= (UNIT_FIX >> 1))
				octant_trig(f, c, s);
			else
				octant_trig(UNIT_FIX - f, s, c);
			ci = fix_round(c);
			si = fix_round(s);
			case (quad)
				0: begin xi = ci; xq = si; end
				1: begin xi = -si; xq = ci; end
				2: begin xi = -ci; xq = -si; end
				default: begin xi = si; xq = -ci; end
			endcase
		end else begin
			h = k / 2;
			lm = (1 << h) - 1;
			row = int'(gray_to_bin(idx >> h) & lm);
			col = int'(gray_to_bin(idx & lm) & lm);
			nr = 2 * col - int'(lm);
			ni = int'(lm) - 2 * row;
			vr = (((nr < 0 ? -nr : nr) << (FRAC + 1)) + int'(lm)) / (2 * int'(lm));
			vi = (((ni < 0 ? -ni : ni) << (FRAC + 1)) + int'(lm)) / (2 * int'(lm));
			xi = nr < 0 ? -vr : vr;
			xq = ni < 0 ? -vi : vi;
		end
	endfunction

	function automatic res_t map_or_slice(sym_t s);
		res_t        r;
		int unsigned k;
		int unsigned m;
		int unsigned best;
		int          xi;
		int          xq;
		longint      di;
		longint      dq;
		longint      d2;
		longint      best_d;
		k = order_bits(mode_kind, mode_bits);
		m = 1 << k;
		xi = 0;
		xq = 0;
		best = 0;
		best_d = 0;
		if (s.cmd == CMD_MOD) begin
			best = 32'(s.symbol_index) & (m - 1);
			const_point(mode_kind, k, best, xi, xq);
		end else begin
			for (int unsigned n = 0; n < m; n++) begin
				const_point(mode_kind, k, n, xi, xq);
				di = longint'($signed(s.in_i)) - xi;
				dq = longint'($signed(s.in_q)) - xq;
				d2 = di * di + dq * dq;
				if (n == 0 || d2 < best_d) begin
					best_d = d2;
					best = n;
				end
			end
			xi = 0;
			xq = 0;
		end
		r.out_i = xi[CRD_W-1:0];
		r.out_q = xq[CRD_W-1:0];
		r.out_index = best[IDX_W-1:0];
		return r;
	endfunction

	function automatic logic [CRD_W-1:0] sat16(int v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[CRD_W-1:0];
	endfunction

	// Called at a falling edge; returns at the falling edge after the symbol is accepted.
	task automatic put_sym(sym_t s, res_t want);
		sym_valid <= 1'b1;
		sym <= s;
		do @(posedge clk); while (!sym_ready);
		pending_res.push_back(want);
		n_items++;
		if (s.cmd == CMD_DEMOD) n_demod++;
		@(negedge clk);
	endtask

	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			sym_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
	endtask

	task automatic drain_results();
		sym_valid <= 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_KIND)
			mode_kind = data[0];
		else
			mode_bits = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_mode(logic kind, logic [KW-1:0] bits, bit both);
		drain_results();
		if (both || kind != mode_kind) write_reg(CFG_KIND, {2'b00, kind});
		if (both || bits != mode_bits) write_reg(CFG_BITS, bits);
		n_settings++;
	endtask

	task automatic rand_sym(output sym_t s);
		int unsigned k;
		int unsigned m;
		int          xi;
		int          xq;
		int          yi;
		int          yq;
		int          amp;
		k = order_bits(mode_kind, mode_bits);
		m = 1 << k;
		s.cmd = 1'($urandom_range(0, 1));
		s.symbol_index = IDX_W'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				s.in_i = CRD_W'($urandom);
				s.in_q = CRD_W'($urandom);
			end
			1, 2: begin
				amp = ($urandom_range(0, 1) == 0) ? 64 : 4000;
				const_point(mode_kind, k, $urandom_range(0, 63) & (m - 1), xi, xq);
				s.in_i = sat16(xi + int'($urandom_range(0, 2 * amp)) - amp);
				s.in_q = sat16(xq + int'($urandom_range(0, 2 * amp)) - amp);
			end
			default: begin
				const_point(mode_kind, k, $urandom_range(0, 63) & (m - 1), xi, xq);
				const_point(mode_kind, k, $urandom_range(0, 63) & (m - 1), yi, yq);
				s.in_i = sat16((xi + yi) / 2);
				s.in_q = sat16((xq + yq) / 2);
			end
		endcase
	endtask

	always @(negedge clk) begin
		stall_cnt++;
		if (stall_cnt >= 150) begin
			stall_cnt = 0;
			stall_mode = $urandom_range(0, 3);
		end
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			2: res_ready <= (stall_cnt % 5 == 0);
			default: res_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		res_t want;
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench NOT OK");
			$finish;
		end
		if (arst_n && res_valid && res_ready) begin
			if (pending_res.size() == 0) begin
				if (fails < 10)
					$display("unexpected result i=%0d q=%0d idx=%0d",
						res.out_i, res.out_q, res.out_index);
				fails++;
			end else begin
				want = pending_res.pop_front();
				n_checked++;
				if (res.out_i !== want.out_i || res.out_q !== want.out_q ||
						res.out_index !== want.out_index) begin
					if (fails < 10)
						$display({"mismatch: expected i=%0d q=%0d idx=%0d, ",
							"got i=%0d q=%0d idx=%0d"},
							want.out_i, want.out_q, want.out_index,
							res.out_i, res.out_q, res.out_index);
					fails++;
				end
			end
		end
	end

	initial begin
		sym_t s;
		res_t want;
		mode_kind = KIND_QAM;
		mode_bits = RST_BITS;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			if (DIR_TAB[r].kind != mode_kind || DIR_TAB[r].bits != mode_bits)
				set_mode(DIR_TAB[r].kind, DIR_TAB[r].bits, 1'b0);
			s.cmd = DIR_TAB[r].cmd;
			s.symbol_index = DIR_TAB[r].idx;
			s.in_i = DIR_TAB[r].ii;
			s.in_q = DIR_TAB[r].qq;
			if (DIR_TAB[r].typed) begin
				want.out_i = DIR_TAB[r].ei;
				want.out_q = DIR_TAB[r].eq;
				want.out_index = DIR_TAB[r].eidx;
			end else begin
				want = map_or_slice(s);
			end
			put_sym(s, want);
			pace();
		end

		for (int p = 0; p < PHASES; p++) begin
			set_mode(1'(p % 2), KW'($urandom_range(0, 7)), 1'b1);
			for (int n = 0; n < PER_PHASE; n++) begin
				rand_sym(s);
				put_sym(s, map_or_slice(s));
				pace();
				if (p == 4 && n == PER_PHASE / 2) drain_results();
			end
		end

		drain_results();
		repeat (80) @(posedge clk);
		if (pending_res.size() != 0) fails++;
		$display("Sent %0d symbol transactions (%0d demodulate) over %0d mode settings;",
			n_items, n_demod, n_settings);
		$display("%0d results compared, %0d failures.", n_checked, fails);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
